// ===== hw/rtl/tlf_pkg.sv =====
// tlf_pkg: shared types and constants of the tilemap layer fetch unit
// no dependencies; used by tlf_tile_ram.sv and the top level
package tlf_pkg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ
    } t_state;

    localparam logic [3:0] ACT_SET_PTR      = 4'd0;
    localparam logic [3:0] ACT_READ_PTR     = 4'd1;
    localparam logic [3:0] ACT_WRITE_TILE   = 4'd2;
    localparam logic [3:0] ACT_READ_TILE    = 4'd3;
    localparam logic [3:0] ACT_WRITE_SCROLL = 4'd4;
    localparam logic [3:0] ACT_READ_SCROLL  = 4'd5;
    localparam logic [3:0] ACT_SCREEN_OFS   = 4'd6;
    localparam logic [3:0] ACT_LAYER_ADJ    = 4'd7;
    localparam logic [3:0] ACT_FETCH        = 4'd8;

    localparam logic [15:0] SCROLL_X_BIAS = 16'h01f0;
    localparam logic [15:0] SCROLL_Y_BIAS = 16'h0101;

    // per-layer bias subtracted on adjust writes, layer 0 in the lowest slot
    localparam logic [3:0][8:0] ADJ_BIAS = {9'h007, 9'h085, 9'h014, 9'h0db};

    typedef struct packed {
        logic       en;
        logic [3:0] be;
    } t_ram_wr;

endpackage

// ===== hw/rtl/tlf_if.sv =====
// tlf_in_if, tlf_out_if: valid/ready channels of the tilemap layer fetch unit
// no dependencies
interface tlf_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [2:0]  index;
    logic [15:0] write_value;
    logic [1:0]  byte_enable;
    logic [1:0]  layer;
    logic [5:0]  cell_col;
    logic [4:0]  cell_row;

    modport source (output valid, action, index, write_value, byte_enable, layer,
                    cell_col, cell_row, input ready);
    modport sink (input valid, action, index, write_value, byte_enable, layer,
                  cell_col, cell_row, output ready);
endinterface

interface tlf_out_if;
    logic              valid;
    logic              ready;
    logic [15:0]       read_data;
    logic              visible;
    logic [3:0]        priority_res;
    logic [14:0]       tile_number;
    logic [5:0]        color;
    logic signed [9:0] x_pos;
    logic signed [8:0] y_pos;

    modport source (output valid, read_data, visible, priority_res, tile_number, color,
                    x_pos, y_pos, input ready);
    modport sink (input valid, read_data, visible, priority_res, tile_number, color,
                  x_pos, y_pos, output ready);
endinterface

// ===== hw/rtl/tilemap_layer_fetch_unit_top.sv =====
// Four-layer scrolling tilemap fetch unit. Register actions (pointer, scroll,
// offsets, adjusts, tile writes) put their result straight into the output
// register; tile reads and cell fetches first pass the registered read port of
// the tile store and state S_READ. One item is in work at a time; a result waiting
// in the output register holds off the next item until that result is taken. After
// reset all 4*ENTRIES_PER_LAYER entries of the tile store are cleared one per cycle,
// with no input taken. ENTRIES_PER_LAYER and MAP_SIDE are powers of two.
// depends on tlf_pkg, tlf_if.sv and tlf_tile_ram
module tilemap_layer_fetch_unit_top #(
    parameter int ENTRIES_PER_LAYER = 4096,
    parameter int MAP_SIDE          = 64,
    parameter int VIEW_COLS         = 41,
    parameter int VIEW_ROWS         = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlf_in_if.sink    i_in,
    tlf_out_if.source o_out
);

    localparam int EPL_W = $clog2(ENTRIES_PER_LAYER);
    localparam int AW    = EPL_W + 2;
    localparam int MS_W  = $clog2(MAP_SIDE);

    tlf_pkg::t_state r_state, n_state;

    logic [AW-1:0]       r_clr_idx;
    logic [15:0]         r_ptr;
    logic [7:0][15:0]    r_scroll;
    logic [1:0][15:0]    r_ofs;
    logic [3:0][8:0]     r_adj;

    // context of an item waiting on the tile store
    logic                r_ctx_fetch;
    logic                r_ctx_half;
    logic                r_ctx_view;
    logic [9:0]          r_ctx_x;
    logic [8:0]          r_ctx_y;

    logic                r_out_valid;
    logic [15:0]         r_out_data;
    logic                r_out_vis;
    logic [3:0]          r_out_prio;
    logic [14:0]         r_out_tile;
    logic [5:0]          r_out_color;
    logic [9:0]          r_out_x;
    logic [8:0]          r_out_y;

    logic                w_accept;
    logic                w_out_free;
    logic                w_needs_read;
    logic                w_clear_done;
    logic [AW-1:0]       w_ptr_addr;
    logic [15:0]         w_sx;
    logic [15:0]         w_sy;
    logic [MS_W-1:0]     w_mcol;
    logic [MS_W-1:0]     w_mrow;
    logic [AW-1:0]       w_fetch_addr;
    logic                w_in_view;
    logic [15:0]         w_imm_data;
    logic [8:0]          w_adj_val;

    tlf_pkg::t_ram_wr    w_ram_wr;
    logic [AW-1:0]       w_ram_wr_addr;
    logic [31:0]         w_ram_wr_data;
    logic                w_ram_rd_en;
    logic [AW-1:0]       w_ram_rd_addr;
    logic [31:0]         w_ram_rd_data;

    assign w_out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready   = (r_state == tlf_pkg::S_IDLE) && w_out_free;
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_needs_read = (i_in.action == tlf_pkg::ACT_READ_TILE)
                          || (i_in.action == tlf_pkg::ACT_FETCH);
    assign w_clear_done = (r_clr_idx == '1);
    assign w_ptr_addr   = r_ptr[AW-1:0];

    // fetch address
    always_comb begin
        w_sx = 16'(r_scroll[{i_in.layer, 1'b0}][15:7]) + tlf_pkg::SCROLL_X_BIAS
               - r_ofs[0] + {{7{r_adj[i_in.layer][8]}}, r_adj[i_in.layer]};
        w_sy = 16'(r_scroll[{i_in.layer, 1'b1}][15:7]) + tlf_pkg::SCROLL_Y_BIAS
               - r_ofs[1];
        w_mcol = w_sx[3 +: MS_W] + MS_W'(i_in.cell_col);
        w_mrow = w_sy[3 +: MS_W] + MS_W'(i_in.cell_row);
        w_fetch_addr = {i_in.layer, {EPL_W{1'b0}}} + AW'({w_mrow, w_mcol});
        w_in_view = ({1'b0, i_in.cell_col} < 7'(VIEW_COLS))
                    && ({2'b0, i_in.cell_row} < 7'(VIEW_ROWS));
        w_adj_val = {1'b0, i_in.write_value[7:0]} - tlf_pkg::ADJ_BIAS[i_in.index[1:0]];
    end

    always_comb begin
        case (i_in.action)
            tlf_pkg::ACT_READ_PTR:    w_imm_data = r_ptr;
            tlf_pkg::ACT_READ_SCROLL: w_imm_data = r_scroll[i_in.index];
            default:                  w_imm_data = '0;
        endcase
    end

    // tile store ports
    always_comb begin
        w_ram_wr      = '0;
        w_ram_wr_addr = w_ptr_addr;
        w_ram_wr_data = {i_in.write_value, i_in.write_value};
        w_ram_rd_en   = w_accept && w_needs_read;
        w_ram_rd_addr = (i_in.action == tlf_pkg::ACT_FETCH) ? w_fetch_addr : w_ptr_addr;
        if (r_state == tlf_pkg::S_CLEAR) begin
            w_ram_wr.en   = 1'b1;
            w_ram_wr.be   = 4'hf;
            w_ram_wr_addr = r_clr_idx;
            w_ram_wr_data = '0;
        end else if (w_accept && (i_in.action == tlf_pkg::ACT_WRITE_TILE)) begin
            w_ram_wr.en = 1'b1;
            w_ram_wr.be = i_in.index[0] ? {2'b00, i_in.byte_enable}
                                        : {i_in.byte_enable, 2'b00};
        end
    end

    tlf_tile_ram #(
        .AW (AW)
    ) u_tile_ram (
        .i_clk     (i_clk),
        .i_wr      (w_ram_wr),
        .i_wr_addr (w_ram_wr_addr),
        .i_wr_data (w_ram_wr_data),
        .i_rd_en   (w_ram_rd_en),
        .i_rd_addr (w_ram_rd_addr),
        .o_rd_data (w_ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlf_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlf_pkg::S_CLEAR: begin
                if (w_clear_done) n_state = tlf_pkg::S_IDLE;
            end
            tlf_pkg::S_IDLE: begin
                if (w_accept && w_needs_read) n_state = tlf_pkg::S_READ;
            end
            tlf_pkg::S_READ: begin
                n_state = tlf_pkg::S_IDLE;
            end
            default: n_state = tlf_pkg::S_IDLE;
        endcase
    end

    // control and register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_ptr       <= '0;
            r_scroll    <= '0;
            r_ofs       <= '0;
            r_adj       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == tlf_pkg::S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == tlf_pkg::S_READ) begin
                r_out_valid <= 1'b1;
            end
            if (w_accept) begin
                if (!w_needs_read) begin
                    r_out_valid <= 1'b1;
                end
                case (i_in.action)
                    tlf_pkg::ACT_SET_PTR: r_ptr <= i_in.write_value;
                    tlf_pkg::ACT_WRITE_TILE: begin
                        if (i_in.index[0]) r_ptr <= r_ptr + 16'd1;
                    end
                    tlf_pkg::ACT_WRITE_SCROLL: r_scroll[i_in.index] <= i_in.write_value;
                    tlf_pkg::ACT_SCREEN_OFS: r_ofs[i_in.index != 3'd0] <= i_in.write_value;
                    tlf_pkg::ACT_LAYER_ADJ: begin
                        if (!i_in.index[2]) r_adj[i_in.index[1:0]] <= w_adj_val;
                    end
                    default: ;
                endcase
            end
        end
    end

    // item context and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ctx_fetch <= (i_in.action == tlf_pkg::ACT_FETCH);
            r_ctx_half  <= i_in.index[0];
            r_ctx_view  <= w_in_view;
            r_ctx_x     <= {1'b0, i_in.cell_col, 3'b000} - {7'b0, w_sx[2:0]};
            r_ctx_y     <= {1'b0, i_in.cell_row, 3'b000} - {6'b0, w_sy[2:0]};
            if (!w_needs_read) begin
                r_out_data  <= w_imm_data;
                r_out_vis   <= 1'b0;
                r_out_prio  <= '0;
                r_out_tile  <= '0;
                r_out_color <= '0;
                r_out_x     <= '0;
                r_out_y     <= '0;
            end
        end
        if (r_state == tlf_pkg::S_READ) begin
            if (r_ctx_fetch) begin
                r_out_data  <= '0;
                r_out_vis   <= r_ctx_view && (w_ram_rd_data[31:28] != 4'd0);
                r_out_prio  <= r_ctx_view ? w_ram_rd_data[31:28] : 4'd0;
                r_out_tile  <= r_ctx_view ? w_ram_rd_data[14:0] : 15'd0;
                r_out_color <= r_ctx_view ? w_ram_rd_data[21:16] : 6'd0;
                r_out_x     <= r_ctx_view ? r_ctx_x : 10'd0;
                r_out_y     <= r_ctx_view ? r_ctx_y : 9'd0;
            end else begin
                r_out_data  <= r_ctx_half ? w_ram_rd_data[15:0] : w_ram_rd_data[31:16];
                r_out_vis   <= 1'b0;
                r_out_prio  <= '0;
                r_out_tile  <= '0;
                r_out_color <= '0;
                r_out_x     <= '0;
                r_out_y     <= '0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.read_data    = r_out_data;
    assign o_out.visible      = r_out_vis;
    assign o_out.priority_res = r_out_prio;
    assign o_out.tile_number  = r_out_tile;
    assign o_out.color        = r_out_color;
    assign o_out.x_pos        = signed'(r_out_x);
    assign o_out.y_pos        = signed'(r_out_y);

endmodule

// ===== hw/rtl/tlf_tile_ram.sv =====
// tlf_tile_ram: tile store, one write port with byte lanes, one registered read port
// depends on tlf_pkg
module tlf_tile_ram #(
    parameter int AW = 14
) (
    input  logic             i_clk,
    input  tlf_pkg::t_ram_wr i_wr,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [31:0]      i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [31:0]      o_rd_data
);

    logic [31:0] r_mem [2**AW];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            for (int b = 0; b < 4; b++) begin
                if (i_wr.be[b]) begin
                    r_mem[i_wr_addr][b*8 +: 8] <= i_wr_data[b*8 +: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
